### hdl/salc_pkg.sv
// Shared types, constants and codes for the LRU cache statistics block.
`timescale 1ns / 1ps
package salc_pkg;

   localparam int MAX_SET_BITS = 6;
   localparam int MAX_WAYS     = 8;
   localparam int NUM_SETS     = 1 << MAX_SET_BITS;
   localparam int SET_W        = MAX_SET_BITS;
   localparam int WAY_W        = 3;
   localparam int RANK_W       = 3;
   localparam int COUNT_W      = 4;
   localparam int ADDR_W       = 32;
   localparam int TAG_W        = 32;
   localparam int CNT_W        = 32;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 5;

   // access kinds
   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_STORE  = 2'd1;
   localparam logic [1:0] FUNC_MODIFY = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   // access outcomes
   localparam logic [1:0] OUT_HIT        = 2'd0;
   localparam logic [1:0] OUT_MISS       = 2'd1;
   localparam logic [1:0] OUT_MISS_EVICT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_USED  = 2'd2;

   localparam logic [2:0] SET_BITS_RST   = 3'd4;
   localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
   localparam logic [3:0] WAYS_USED_RST  = 4'd8;

   typedef struct packed {
      logic [1:0]        func;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]       outcome;
      logic [SET_W-1:0] set_index;
      logic [CNT_W-1:0] hit_total;
      logic [CNT_W-1:0] miss_total;
      logic [CNT_W-1:0] eviction_total;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [RANK_W-1:0] rank;
      logic [TAG_W-1:0]  tag;
   } line_type;

   typedef line_type [MAX_WAYS-1:0] row_type;

   typedef struct packed {
      logic rd_req;      // read the set memory this cycle
      logic rd_sel_req;  // take the address from the input beat
      logic load_req;    // capture the input beat
      logic commit;      // write back the set, bump counters, load the result
      logic last;        // final result of this input
   } cmd_type;

endpackage

### hdl/salc_ctrl.sv
// Sequencer for the cache block: accepts beats, steps accesses, owns result valid.
`timescale 1ns / 1ps
module salc_ctrl
   import salc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_READ   = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       modify_ff, modify_in;
   logic       second_ff, second_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;
   logic       last_access;

   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign last_access = !modify_ff || second_ff;
   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      modify_in  = modify_ff;
      second_in  = second_ff;
      cmd        = '0;
      cmd.last   = last_access;
      case (state_ff)
         S_IDLE: begin
            // a FUNC_NONE beat is taken and dropped
            if (req_valid && req_data.func != FUNC_NONE) begin
               cmd.load_req   = 1'b1;
               cmd.rd_req     = 1'b1;
               cmd.rd_sel_req = 1'b1;
               modify_in      = (req_data.func == FUNC_MODIFY);
               second_in      = 1'b0;
               state_in       = S_UPDATE;
            end
         end
         S_READ: begin
            cmd.rd_req = 1'b1;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            // hold until the result register can take the beat
            if (slot_free) begin
               cmd.commit = 1'b1;
               if (last_access) begin
                  state_in = S_IDLE;
               end else begin
                  second_in = 1'b1;
                  state_in  = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         modify_ff    <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modify_ff    <= modify_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/salc_dpath.sv
// Datapath: config registers, set memory, tag compare, LRU update and counters.
`timescale 1ns / 1ps
module salc_dpath
   import salc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  req_type               req_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output rsp_type               rsp_data
);

   logic [2:0] set_bits_ff;
   logic [4:0] block_bits_ff;
   logic [3:0] ways_used_ff;

   row_type             set_mem [NUM_SETS];
   logic [NUM_SETS-1:0] row_valid_ff;

   logic [ADDR_W-1:0] addr_ff;
   logic [SET_W-1:0]  set_ff;
   logic [TAG_W-1:0]  tag_ff;
   row_type           rd_row_ff;
   logic              row_live_ff;

   logic [CNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0] miss_cnt_ff, miss_cnt_in;
   logic [CNT_W-1:0] evict_cnt_ff, evict_cnt_in;
   rsp_type          rsp_ff, rsp_in;

   // address split
   logic [ADDR_W-1:0] rd_addr;
   logic [2:0]        sb_eff;
   logic [SET_W-1:0]  set_mask;
   logic [ADDR_W-1:0] addr_shift;
   logic [5:0]        tag_shift;
   logic [SET_W-1:0]  rd_set;
   logic [TAG_W-1:0]  rd_tag;

   assign rd_addr    = cmd.rd_sel_req ? req_data.address : addr_ff;
   assign sb_eff     = (set_bits_ff > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits_ff;
   assign set_mask   = SET_W'((7'd1 << sb_eff) - 7'd1);
   assign addr_shift = rd_addr >> block_bits_ff;
   assign rd_set     = addr_shift[SET_W-1:0] & set_mask;
   assign tag_shift  = {3'b000, sb_eff} + {1'b0, block_bits_ff};
   assign rd_tag     = (tag_shift >= 6'd32) ? '0 : (rd_addr >> tag_shift);

   // set search
   row_type             row_eff;
   logic                hit_found;
   logic [WAY_W-1:0]    hit_way;
   logic [RANK_W-1:0]   hit_rank;
   logic [COUNT_W-1:0]  line_count;
   logic                free_found;
   logic [WAY_W-1:0]    free_way;
   logic                lru_found;
   logic [WAY_W-1:0]    lru_way;
   logic [RANK_W-1:0]   lru_rank;
   logic [COUNT_W-1:0]  ways_eff;
   logic                evict;
   logic [WAY_W-1:0]    target;
   row_type             new_row;

   assign row_eff  = row_live_ff ? rd_row_ff : '0;
   assign ways_eff = (ways_used_ff == 4'd0) ? 4'd1 :
                     (ways_used_ff > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : ways_used_ff;

   always_comb begin
      hit_found  = 1'b0;
      hit_way    = '0;
      line_count = '0;
      free_found = 1'b0;
      free_way   = '0;
      lru_found  = 1'b0;
      lru_way    = '0;
      lru_rank   = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (row_eff[w].valid) begin
            line_count = line_count + 4'd1;
            if (!hit_found && row_eff[w].tag == tag_ff) begin
               hit_found = 1'b1;
               hit_way   = WAY_W'(w);
            end
            if (!lru_found || row_eff[w].rank > lru_rank) begin
               lru_found = 1'b1;
               lru_way   = WAY_W'(w);
               lru_rank  = row_eff[w].rank;
            end
         end else if (!free_found) begin
            free_found = 1'b1;
            free_way   = WAY_W'(w);
         end
      end
   end

   assign hit_rank = row_eff[hit_way].rank;
   assign evict    = !hit_found && ((line_count >= ways_eff) || !free_found);
   assign target   = evict ? lru_way : free_way;

   always_comb begin
      new_row = row_eff;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (hit_found) begin
            if (row_eff[w].valid && row_eff[w].rank < hit_rank) begin
               new_row[w].rank = row_eff[w].rank + 3'd1;
            end
         end else if (row_eff[w].valid && WAY_W'(w) != target) begin
            new_row[w].rank = row_eff[w].rank + 3'd1;
         end
      end
      if (hit_found) begin
         new_row[hit_way].rank = '0;
      end else begin
         new_row[target].tag   = tag_ff;
         new_row[target].valid = 1'b1;
         new_row[target].rank  = '0;
      end
   end

   always_comb begin
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      evict_cnt_in = evict_cnt_ff;
      if (hit_found) begin
         hit_cnt_in = hit_cnt_ff + 32'd1;
      end else begin
         miss_cnt_in = miss_cnt_ff + 32'd1;
         if (evict) begin
            evict_cnt_in = evict_cnt_ff + 32'd1;
         end
      end
      rsp_in.outcome        = hit_found ? OUT_HIT : (evict ? OUT_MISS_EVICT : OUT_MISS);
      rsp_in.set_index      = set_ff;
      rsp_in.hit_total      = hit_cnt_in;
      rsp_in.miss_total     = miss_cnt_in;
      rsp_in.eviction_total = evict_cnt_in;
      rsp_in.last           = cmd.last;
   end

   assign rsp_data = rsp_ff;

   // control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= SET_BITS_RST;
         block_bits_ff <= BLOCK_BITS_RST;
         ways_used_ff  <= WAYS_USED_RST;
         row_valid_ff  <= '0;
         row_live_ff   <= 1'b0;
         hit_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
         evict_cnt_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SET_BITS:   set_bits_ff   <= csr_wr_data[2:0];
               CSR_BLOCK_BITS: block_bits_ff <= csr_wr_data;
               CSR_WAYS_USED:  ways_used_ff  <= csr_wr_data[3:0];
               default: ;
            endcase
         end
         if (cmd.rd_req) begin
            row_live_ff <= row_valid_ff[rd_set];
         end
         if (cmd.commit) begin
            row_valid_ff[set_ff] <= 1'b1;
            hit_cnt_ff           <= hit_cnt_in;
            miss_cnt_ff          <= miss_cnt_in;
            evict_cnt_ff         <= evict_cnt_in;
         end
      end
   end

   // payload registers and set memory
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         addr_ff <= req_data.address;
      end
      if (cmd.rd_req) begin
         rd_row_ff <= set_mem[rd_set];
         set_ff    <= rd_set;
         tag_ff    <= rd_tag;
      end
      if (cmd.commit) begin
         set_mem[set_ff] <= new_row;
         rsp_ff          <= rsp_in;
      end
   end

endmodule

### hdl/set_assoc_lru_cache_sim_top.sv
// Set-associative LRU cache statistics block: top level.
// Each access reads one set row from the set memory, compares tags and
// updates LRU ranks, then writes the row back; a modify makes two accesses.
// A write-back waits while the result register is full and rsp_ready is low.
// Up to 64 sets of 8 ways; set_bits, block_bits and ways_used are written
// through the csr_ port; the user must write them only while no access is in
// flight, and the block itself does not enforce it. Valid state is tracked
// per set in flops cleared by reset, so the set memory needs no clearing.
`timescale 1ns / 1ps
module set_assoc_lru_cache_sim_top
   import salc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cmd_type cmd;

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   salc_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_data)
   );

endmodule

### hdl/salc_chk.sv
// Port checker for the cache block and its bind to the top level.
`timescale 1ns / 1ps
module salc_chk
   import salc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input req_type               req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_data,
   input logic                  csr_wr_en,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wr_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.outcome == OUT_HIT || rsp_data.outcome == OUT_MISS ||
                     rsp_data.outcome == OUT_MISS_EVICT))
      else $error("illegal outcome code");

   // the second access of a modify is still pending, so no new beat is taken
   a_modify_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !req_ready)
      else $error("input taken while a modify is unfinished");

endmodule

bind set_assoc_lru_cache_sim_top salc_chk u_chk (.*);

### verif/tb.sv
// Self-checking testbench for the LRU cache statistics block, with a predictor and random beats.
`timescale 1ns / 1ps
module tb;
   import salc_pkg::*;

   localparam int LIMIT       = 200000;
   localparam int TAIL_CYCLES = 16;
   localparam int PHASE_ITEMS = 75;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   set_assoc_lru_cache_sim_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cache image and settings as the block should see them
   logic [2:0]  cfg_set_bits   = SET_BITS_RST;
   logic [4:0]  cfg_block_bits = BLOCK_BITS_RST;
   logic [3:0]  cfg_ways_used  = WAYS_USED_RST;
   bit [TAG_W-1:0]  line_tag   [NUM_SETS][MAX_WAYS];
   bit              line_valid [NUM_SETS][MAX_WAYS];
   bit [RANK_W-1:0] line_rank  [NUM_SETS][MAX_WAYS];
   bit [CNT_W-1:0]  hit_count;
   bit [CNT_W-1:0]  miss_count;
   bit [CNT_W-1:0]  evict_count;

   req_type access_queue [$];
   rsp_type result_queue [$];
   int      errors      = 0;
   int      cycle_count = 0;
   bit      hold_wanted = 0;

   function automatic int eff_set_bits();
      return (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
   endfunction

   function automatic int eff_ways();
      int ways;
      ways = int'(cfg_ways_used);
      if (ways == 0) ways = 1;
      if (ways > MAX_WAYS) ways = MAX_WAYS;
      return ways;
   endfunction

   // one tag lookup with LRU update; queues the result it causes
   function automatic void cache_lookup(input logic [31:0] addr, input bit is_last);
      int sb, bb, ways, set_i, sh, hit_way, free_way, lru_way, count, target;
      logic [TAG_W-1:0]  tag;
      logic [RANK_W-1:0] lru_rank, hit_rank;
      rsp_type res;
      sb   = eff_set_bits();
      bb   = int'(cfg_block_bits);
      ways = eff_ways();
      set_i = (sb == 0) ? 0 : int'((addr >> bb) & ((32'd1 << sb) - 32'd1));
      sh   = sb + bb;
      tag  = (sh >= 32) ? '0 : addr >> sh;
      hit_way  = -1;
      free_way = -1;
      lru_way  = -1;
      count    = 0;
      lru_rank = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (line_valid[set_i][w]) begin
            count++;
            if (hit_way < 0 && line_tag[set_i][w] == tag) hit_way = w;
            if (lru_way < 0 || line_rank[set_i][w] > lru_rank) begin
               lru_way  = w;
               lru_rank = line_rank[set_i][w];
            end
         end else if (free_way < 0) begin
            free_way = w;
         end
      end
      if (hit_way >= 0) begin
         hit_rank = line_rank[set_i][hit_way];
         for (int w = 0; w < MAX_WAYS; w++)
            if (line_valid[set_i][w] && line_rank[set_i][w] < hit_rank) line_rank[set_i][w]++;
         line_rank[set_i][hit_way] = '0;
         hit_count++;
         res.outcome = OUT_HIT;
      end else begin
         if (count >= ways || free_way < 0) begin
            target = lru_way;
            evict_count++;
            res.outcome = OUT_MISS_EVICT;
         end else begin
            target = free_way;
            res.outcome = OUT_MISS;
         end
         miss_count++;
         for (int w = 0; w < MAX_WAYS; w++)
            if (line_valid[set_i][w] && w != target) line_rank[set_i][w]++;
         line_tag[set_i][target]   = tag;
         line_valid[set_i][target] = 1'b1;
         line_rank[set_i][target]  = '0;
      end
      res.set_index      = set_i[SET_W-1:0];
      res.hit_total      = hit_count;
      res.miss_total     = miss_count;
      res.eviction_total = evict_count;
      res.last           = is_last;
      result_queue.push_back(res);
   endfunction

   function automatic void predict_access(input req_type beat);
      case (beat.func)
         FUNC_LOAD, FUNC_STORE: cache_lookup(beat.address, 1'b1);
         FUNC_MODIFY: begin
            cache_lookup(beat.address, 1'b0);
            cache_lookup(beat.address, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // build an address from tag, set and offset under the current settings
   function automatic logic [31:0] compose_addr(input logic [31:0] tag, input int set_i,
                                                input logic [31:0] offset);
      int sb, bb;
      logic [63:0] a;
      sb = eff_set_bits();
      bb = int'(cfg_block_bits);
      a  = ({32'b0, tag} << (sb + bb))
         | ((64'(set_i) & ((64'd1 << sb) - 64'd1)) << bb)
         | (64'(offset) & ((64'd1 << bb) - 64'd1));
      return a[31:0];
   endfunction

   function automatic req_type make_beat(input logic [1:0] func, input logic [31:0] addr);
      req_type b;
      b.func    = func;
      b.address = addr;
      return b;
   endfunction

   // driver: bursts of beats with random gaps
   int burst_left = 0;
   int gap_left   = 0;
   bit offer;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            predict_access(req_data);
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (access_queue.size() > 0) begin
               req_data <= access_queue.pop_front();
               offer = 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_valid <= offer;
      end
   end

   // monitor: stall pattern, one long hold-off, and result checks
   int      stall_mode = 0;
   int      mode_left  = 0;
   int      hold_left  = 0;
   bit      hold_done  = 0;
   int      pattern_cnt = 0;
   rsp_type want_beat;

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t tb: %s expected %h got %h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (result_queue.size() == 0) begin
               $display("%0t tb: unexpected result beat %h", $time, rsp_data);
               errors++;
            end else begin
               want_beat = result_queue.pop_front();
               check_field("outcome", 32'(want_beat.outcome), 32'(rsp_data.outcome));
               check_field("set_index", 32'(want_beat.set_index), 32'(rsp_data.set_index));
               check_field("hit_total", want_beat.hit_total, rsp_data.hit_total);
               check_field("miss_total", want_beat.miss_total, rsp_data.miss_total);
               check_field("eviction_total", want_beat.eviction_total,
                           rsp_data.eviction_total);
               check_field("last", 32'(want_beat.last), 32'(rsp_data.last));
            end
         end
         pattern_cnt++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_wanted && !hold_done) begin
            hold_done = 1;
            hold_left = 400;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(20, 150);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (pattern_cnt % 7) < 4;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (access_queue.size() != 0 || req_valid || result_queue.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      case (idx)
         CSR_SET_BITS:   cfg_set_bits   = value[2:0];
         CSR_BLOCK_BITS: cfg_block_bits = value[4:0];
         CSR_WAYS_USED:  cfg_ways_used  = value[3:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int sb, input int bb, input int ways);
      write_reg(CSR_SET_BITS, CSR_DATA_W'(sb));
      write_reg(CSR_BLOCK_BITS, CSR_DATA_W'(bb));
      write_reg(CSR_WAYS_USED, CSR_DATA_W'(ways));
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int          counted, pick, set_i, pool;
      logic [1:0]  func;
      logic [31:0] tag_base, tag;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed beats under reset settings: 16 sets, 16-byte blocks, 8 ways
      access_queue.push_back(make_beat(FUNC_LOAD, 32'h0000_0000));
      access_queue.push_back(make_beat(FUNC_LOAD, 32'h0000_000F));
      access_queue.push_back(make_beat(FUNC_STORE, 32'h0000_0010));
      access_queue.push_back(make_beat(FUNC_MODIFY, 32'hFFFF_FFFF));
      access_queue.push_back(make_beat(FUNC_NONE, 32'h1234_5678));
      for (int t = 1; t <= 8; t++)
         access_queue.push_back(make_beat(FUNC_LOAD, 32'(t) << 8));
      access_queue.push_back(make_beat(FUNC_LOAD, 32'h0000_0100));
      access_queue.push_back(make_beat(FUNC_MODIFY, 32'h0000_0000));
      access_queue.push_back(make_beat(FUNC_LOAD, 32'h8000_0000));
      access_queue.push_back(make_beat(FUNC_STORE, 32'h7FFF_FFF0));
      access_queue.push_back(make_beat(FUNC_NONE, 32'hFFFF_FFFF));
      wait_idle();

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: apply_settings(0, 0, 1);
            1: apply_settings(6, 25, 8);
            2: apply_settings(7, 31, 15);
            3: apply_settings(3, 2, 0);
            4: apply_settings(2, 3, 8);
            5: apply_settings(2, 3, 2);    // ways lowered with lines still valid
            6: apply_settings(6, 26, 5);   // tag shift reaches 32
            default: apply_settings($urandom_range(0, 7), $urandom_range(0, 31),
                                    $urandom_range(0, 15));
         endcase
         if (phase == 1) hold_wanted = 1;
         tag_base = $urandom;
         pool     = eff_ways() + 3;
         counted  = 0;
         while (counted < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            func = 2'($urandom_range(0, 2));
            if (pick < 80) begin
               // hits, fills and evictions on a few sets
               set_i = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NUM_SETS - 1)
                                                   : $urandom_range(0, 3);
               tag   = tag_base + $urandom_range(0, pool - 1);
               access_queue.push_back(make_beat(func, compose_addr(tag, set_i, $urandom)));
               counted++;
            end else if (pick < 93) begin
               access_queue.push_back(make_beat(func, $urandom));
               counted++;
            end else begin
               access_queue.push_back(make_beat(FUNC_NONE, $urandom));
            end
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/salc_pkg.sv
hdl/salc_ctrl.sv
hdl/salc_dpath.sv
hdl/set_assoc_lru_cache_sim_top.sv
hdl/salc_chk.sv
verif/tb.sv
